// ===== sv/ctq_pkg.sv =====
// Shared types and constants of the credit throttle with its wait queue.
package ctq_pkg;

  localparam int CREDIT_W = 35;
  localparam int AMOUNT_W = 32;
  localparam int TAG_W    = 8;
  localparam int STATUS_W = 3;
  localparam int OUTCR_W  = 34;

  // Most results that one tick may release.
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic signed [CREDIT_W-1:0] CREDIT_MAX = 35'sh1_FFFF_FFFF;

  // Register indexes of the configuration port.
  localparam logic REG_CREDIT_PER_TICK = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_RELEASED = 3'd2,
    ST_REJECTED = 3'd3,
    ST_NONE     = 3'd4
  } ctq_status_e;

  typedef enum logic {
    KIND_REQUEST = 1'b0,
    KIND_TICK    = 1'b1
  } ctq_kind_e;

  typedef struct packed {
    logic                wr;
    logic [AMOUNT_W-1:0] value;
  } ctq_cfg_t;

endpackage

// ===== sv/ctq_store.sv =====
// Wait queue storage: one synchronous memory of amount and tag per entry.
module ctq_store #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ADDR_W      = 4
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [ADDR_W-1:0]          wr_addr_i,
  input  logic [ctq_pkg::AMOUNT_W-1:0] wr_amount_i,
  input  logic [ctq_pkg::TAG_W-1:0]    wr_tag_i,
  input  logic                       rd_en_i,
  input  logic [ADDR_W-1:0]          rd_addr_i,
  output logic [ctq_pkg::AMOUNT_W-1:0] rd_amount_o,
  output logic [ctq_pkg::TAG_W-1:0]    rd_tag_o
);
  import ctq_pkg::*;

  localparam int WORD_W = AMOUNT_W + TAG_W;

  logic [WORD_W-1:0] mem [QUEUE_DEPTH];
  logic [WORD_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_amount_i, wr_tag_i};
    end
  end

  // Read data is registered and holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_amount_o = rd_q[WORD_W-1:TAG_W];
  assign rd_tag_o    = rd_q[TAG_W-1:0];

endmodule

// ===== sv/ctq_ctrl.sv =====
// Credit bookkeeping, queue pointers, release sequencer and result register.
module ctq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ADDR_W      = 4,
  parameter int FILL_W      = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctq_pkg::ctq_cfg_t             cfg_i,
  output logic [ctq_pkg::AMOUNT_W-1:0]  credit_per_tick_o,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [ctq_pkg::AMOUNT_W-1:0]  amount_i,
  input  logic [ctq_pkg::TAG_W-1:0]     tag_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ctq_pkg::STATUS_W-1:0]  status_o,
  output logic [ctq_pkg::TAG_W-1:0]     out_tag_o,
  output logic signed [ctq_pkg::OUTCR_W-1:0] credit_after_o,
  output logic                          last_o,
  output logic                          wr_en_o,
  output logic [ADDR_W-1:0]             wr_addr_o,
  output logic [ctq_pkg::AMOUNT_W-1:0]  wr_amount_o,
  output logic [ctq_pkg::TAG_W-1:0]     wr_tag_o,
  output logic                          rd_en_o,
  output logic [ADDR_W-1:0]             rd_addr_o,
  input  logic [ctq_pkg::AMOUNT_W-1:0]  rd_amount_i,
  input  logic [ctq_pkg::TAG_W-1:0]     rd_tag_i
);
  import ctq_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL     = FILL_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]  CAP      = CNT_W'(MAX_RESULTS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_REL  = 2'b10
  } ctq_state_e;

  function automatic logic is_pos(logic signed [CREDIT_W-1:0] v);
    return !v[CREDIT_W-1] && (v != '0);
  endfunction

  ctq_state_e                  state_q, state_d;
  logic [AMOUNT_W-1:0]         cpt_q, cpt_d;
  logic signed [CREDIT_W-1:0]  credit_q, credit_d;
  logic [ADDR_W-1:0]           head_q, head_d, tail_q, tail_d;
  logic [FILL_W-1:0]           fill_q, fill_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;

  logic                        out_valid_q, out_valid_d;
  logic                        load;
  ctq_status_e                 status_q, status_d;
  logic [TAG_W-1:0]            tag_q, tag_d;
  logic signed [OUTCR_W-1:0]   cr_q, cr_d;
  logic                        last_q, last_d;

  logic                        unlimited, out_free, in_acc;
  logic signed [CREDIT_W-1:0]  sum, sat, charged;
  logic [ADDR_W-1:0]           head_nx;
  logic [FILL_W-1:0]           fill_dec;
  logic [CNT_W-1:0]            cnt_inc;
  logic                        rel_last;

  assign unlimited = (cpt_q == '0);
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc    = in_valid_i && in_ready_o;

  assign sum      = credit_q + $signed({3'b000, cpt_q});
  assign sat      = (sum > CREDIT_MAX) ? CREDIT_MAX : sum;
  assign charged  = unlimited ? credit_q : credit_q - $signed({3'b000, rd_amount_i});
  assign head_nx  = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
  assign fill_dec = fill_q - 1'b1;
  assign cnt_inc  = cnt_q + 1'b1;
  // The walk ends when the queue empties, the cap is reached or credit runs out.
  assign rel_last = (fill_dec == '0) || (cnt_inc == CAP) || (!unlimited && !is_pos(charged));

  always_comb begin
    state_d     = state_q;
    cpt_d       = cpt_q;
    credit_d    = credit_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    load        = 1'b0;
    status_d    = ST_GRANTED;
    tag_d       = tag_i;
    cr_d        = credit_q[OUTCR_W-1:0];
    last_d      = 1'b1;
    wr_en_o     = 1'b0;
    wr_addr_o   = tail_q;
    wr_amount_o = amount_i;
    wr_tag_o    = tag_i;
    rd_en_o     = 1'b0;
    rd_addr_o   = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (req_type_i == KIND_REQUEST) begin
            load = 1'b1;
            if (amount_i == '0 || unlimited) begin
              status_d = ST_GRANTED;
            end else if (is_pos(credit_q)) begin
              credit_d = credit_q - $signed({3'b000, amount_i});
              status_d = ST_GRANTED;
            end else if (fill_q == FULL) begin
              status_d = ST_REJECTED;
            end else begin
              wr_en_o  = 1'b1;
              tail_d   = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
              fill_d   = fill_q + 1'b1;
              status_d = ST_QUEUED;
            end
            cr_d = credit_d[OUTCR_W-1:0];
          end else begin
            credit_d = sat;
            if (fill_q != '0 && (unlimited || is_pos(sat))) begin
              rd_en_o = 1'b1;
              cnt_d   = '0;
              state_d = S_REL;
            end else begin
              load     = 1'b1;
              status_d = ST_NONE;
              tag_d    = '0;
              cr_d     = sat[OUTCR_W-1:0];
            end
          end
        end
      end
      S_REL: begin
        if (out_free) begin
          load     = 1'b1;
          status_d = ST_RELEASED;
          tag_d    = rd_tag_i;
          cr_d     = charged[OUTCR_W-1:0];
          last_d   = rel_last;
          credit_d = charged;
          head_d   = head_nx;
          fill_d   = fill_dec;
          cnt_d    = cnt_inc;
          if (rel_last) begin
            state_d = S_IDLE;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = head_nx;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A register write restarts the bucket; the user must write it only while idle, as the block does not enforce it.
    if (cfg_i.wr) begin
      cpt_d    = cfg_i.value;
      credit_d = $signed({3'b000, cfg_i.value});
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cpt_q       <= '0;
      credit_q    <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cpt_q       <= cpt_d;
      credit_q    <= credit_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      tag_q    <= tag_d;
      cr_q     <= cr_d;
      last_q   <= last_d;
    end
  end

  assign credit_per_tick_o = cpt_q;
  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign out_tag_o         = tag_q;
  assign credit_after_o    = cr_q;
  assign last_o            = last_q;

endmodule

// ===== sv/credit_throttle_with_queue.sv =====
// Top level of the credit throttle: register port, control and queue memory.
//
//   Channel | Direction | Handshake          | Word
//   input   | in        | in_valid/in_ready  | req_type, amount, tag
//   result  | out       | out_valid/out_ready| status, out_tag, credit_after, last
//   config  | in        | APB, pready high   | credit_per_tick at address 0
//
// A request gives one result; a new word is taken whenever the sequencer is idle and
// the result register is empty or being emptied. A tick that releases nothing
// also gives one result. A tick that releases n queued requests first issues
// the first memory read, then gives one result per release from the queue
// memory's single read port. Output stalls hold the sequencer in place.
// Reset clears credit, setting and pointers at once; the memory is not cleared.
module credit_throttle_with_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic [ctq_pkg::AMOUNT_W-1:0]       amount_i,
  input  logic [ctq_pkg::TAG_W-1:0]          tag_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ctq_pkg::STATUS_W-1:0]       status_o,
  output logic [ctq_pkg::TAG_W-1:0]          out_tag_o,
  output logic signed [ctq_pkg::OUTCR_W-1:0] credit_after_o,
  output logic                               last_o
);
  import ctq_pkg::*;

  localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  ctq_cfg_t            cfg;
  logic [AMOUNT_W-1:0] cpt;
  logic                reg_hit;

  logic                wr_en, rd_en;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [AMOUNT_W-1:0] wr_amount, rd_amount;
  logic [TAG_W-1:0]    wr_tag, rd_tag;

  assign reg_hit   = (paddr[2] == REG_CREDIT_PER_TICK);
  assign pready    = 1'b1;
  assign cfg.wr    = psel && penable && pwrite && reg_hit;
  assign cfg.value = pwdata;
  assign prdata    = reg_hit ? cpt : '0;

  ctq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ADDR_W     (ADDR_W),
    .FILL_W     (FILL_W)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .credit_per_tick_o(cpt),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .amount_i         (amount_i),
    .tag_i            (tag_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .out_tag_o        (out_tag_o),
    .credit_after_o   (credit_after_o),
    .last_o           (last_o),
    .wr_en_o          (wr_en),
    .wr_addr_o        (wr_addr),
    .wr_amount_o      (wr_amount),
    .wr_tag_o         (wr_tag),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr),
    .rd_amount_i      (rd_amount),
    .rd_tag_i         (rd_tag)
  );

  ctq_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_amount_i(wr_amount),
    .wr_tag_i   (wr_tag),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_amount_o(rd_amount),
    .rd_tag_o   (rd_tag)
  );

endmodule

// ===== sv/ctq_checker.sv =====
// Port-level checks of the credit throttle, bound to its top level.
module ctq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [ctq_pkg::STATUS_W-1:0]       status_o,
  input logic [ctq_pkg::TAG_W-1:0]          out_tag_o,
  input logic signed [ctq_pkg::OUTCR_W-1:0] credit_after_o,
  input logic                               last_o
);
  import ctq_pkg::*;

  localparam logic signed [OUTCR_W-1:0] CREDIT_MIN = 34'sh3_0000_0002;

  // A tick that released nothing reports one final word with a zero tag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NONE |-> last_o && out_tag_o == '0)
    else $error("empty tick result is not final or has a tag");

  // Only releases from the queue can come as several words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_RELEASED |-> last_o)
    else $error("single result not marked last");

  // No new word is taken while a release walk is still under way.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_RELEASED && !last_o |-> !in_ready_o)
    else $error("input taken during a release walk");

  // Credit is charged only while positive, so it has a lower bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> credit_after_o >= CREDIT_MIN)
    else $error("credit below its lower bound");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(out_tag_o) && $stable(credit_after_o) && $stable(last_o))
    else $error("stalled result changed");

endmodule

bind credit_throttle_with_queue ctq_checker u_ctq_checker (.*);

// ===== tb/sv/credit_throttle_with_queue_tb.sv =====
// Testbench of the credit throttle: a directed table, random phases and an in-order word check.
`timescale 1ns / 1ps

module credit_throttle_with_queue_tb;
  import ctq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int HOLD_CYCLES = 150;
  localparam int LIMIT       = 200_000;
  localparam int PHASE_WORDS = 36;
  localparam logic [2:0] RATE_ADDR = {REG_CREDIT_PER_TICK, 2'b00};

  typedef struct packed {
    ctq_status_e               status;
    logic [TAG_W-1:0]          tag;
    logic signed [OUTCR_W-1:0] credit;
    logic                      last;
  } word_t;

  typedef enum logic {
    ROW_WORD,
    ROW_RATE
  } row_op_e;

  typedef struct {
    row_op_e                   op;
    ctq_kind_e                 kind;
    logic [AMOUNT_W-1:0]       amount;
    logic [TAG_W-1:0]          tag;
    int                        reps;
    bit                        typed;
    ctq_status_e               status;
    logic signed [OUTCR_W-1:0] credit;
  } row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [2:0]                  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic                        req_type_i;
  logic [AMOUNT_W-1:0]         amount_i;
  logic [TAG_W-1:0]            tag_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [STATUS_W-1:0]         status_o;
  logic [TAG_W-1:0]            out_tag_o;
  logic signed [OUTCR_W-1:0]   credit_after_o;
  logic                        last_o;

  // Own copy of the throttle state.
  longint                      model_credit = 0;
  logic [AMOUNT_W-1:0]         model_rate = '0;
  logic [AMOUNT_W-1:0]         held_amount[$];
  logic [TAG_W-1:0]            held_tag[$];

  word_t                       step_words[$];
  word_t                       due_words[$];
  word_t                       oldest;
  row_t                        plan[$];
  int                          errors = 0;
  int                          cycles = 0;
  int                          hold_left = 0;
  bit                          steady = 1'b0;

  credit_throttle_with_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .amount_i      (amount_i),
    .tag_i         (tag_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_tag_o     (out_tag_o),
    .credit_after_o(credit_after_o),
    .last_o        (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report(input string msg);
    if (errors < 50) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    errors++;
  endtask

  function automatic word_t credit_word(input ctq_status_e status, input logic [TAG_W-1:0] tag,
                                        input logic last);
    word_t w;
    w.status = status;
    w.tag    = tag;
    w.credit = model_credit[OUTCR_W-1:0];
    w.last   = last;
    return w;
  endfunction

  // Works out the words caused by one accepted input word and updates the state.
  task automatic throttle_predict(input ctq_kind_e kind, input logic [AMOUNT_W-1:0] amt,
                                  input logic [TAG_W-1:0] tag);
    bit                  unlimited;
    bit                  more;
    int                  n;
    logic [AMOUNT_W-1:0] a;
    logic [TAG_W-1:0]    t;
    unlimited = (model_rate == '0);
    step_words.delete();
    if (kind == KIND_REQUEST) begin
      if (amt == '0 || unlimited) begin
        step_words.insert(step_words.size(), credit_word(ST_GRANTED, tag, 1'b1));
      end else if (model_credit > 0) begin
        model_credit -= longint'({32'd0, amt});
        step_words.insert(step_words.size(), credit_word(ST_GRANTED, tag, 1'b1));
      end else if (held_tag.size() >= QUEUE_DEPTH) begin
        step_words.insert(step_words.size(), credit_word(ST_REJECTED, tag, 1'b1));
      end else begin
        held_amount.insert(held_amount.size(), amt);
        held_tag.insert(held_tag.size(), tag);
        step_words.insert(step_words.size(), credit_word(ST_QUEUED, tag, 1'b1));
      end
    end else begin
      model_credit += longint'({32'd0, model_rate});
      if (model_credit > longint'(CREDIT_MAX)) begin
        model_credit = longint'(CREDIT_MAX);
      end
      n = 0;
      more = held_tag.size() > 0 && (unlimited || model_credit > 0);
      while (more) begin
        a = held_amount.pop_front();
        t = held_tag.pop_front();
        if (!unlimited) begin
          model_credit -= longint'({32'd0, a});
        end
        n++;
        more = held_tag.size() > 0 && n < MAX_RESULTS && (unlimited || model_credit > 0);
        step_words.insert(step_words.size(), credit_word(ST_RELEASED, t, !more));
      end
      if (n == 0) begin
        step_words.insert(step_words.size(), credit_word(ST_NONE, '0, 1'b1));
      end
    end
  endtask

  // Offers one input word and, once it is taken, queues what it should cause.
  // A typed row replaces the computed word with the value written in the table.
  task automatic send_word(input ctq_kind_e kind, input logic [AMOUNT_W-1:0] amt,
                           input logic [TAG_W-1:0] tag, input bit typed, input word_t want);
    while (!steady && $urandom_range(99) < 27) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    amount_i   <= amt;
    tag_i      <= tag;
    do @(posedge clk_i); while (!in_ready_o);
    throttle_predict(kind, amt, tag);
    if (typed) begin
      due_words.insert(due_words.size(), want);
    end else begin
      foreach (step_words[j]) due_words.insert(due_words.size(), step_words[j]);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writing the rate also reloads the credit; the queue is kept.
  task automatic write_rate(input logic [AMOUNT_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RATE_ADDR;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    model_rate   = value;
    model_credit = longint'({32'd0, value});
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== value) begin
      report($sformatf("rate read back %h, written %h", prdata, value));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void add_row(input row_op_e op, input ctq_kind_e kind,
                                  input logic [AMOUNT_W-1:0] amt, input logic [TAG_W-1:0] tag,
                                  input int reps, input bit typed, input ctq_status_e status,
                                  input logic signed [OUTCR_W-1:0] credit);
    row_t r;
    r.op     = op;
    r.kind   = kind;
    r.amount = amt;
    r.tag    = tag;
    r.reps   = reps;
    r.typed  = typed;
    r.status = status;
    r.credit = credit;
    plan.insert(plan.size(), r);
  endfunction

  // Receiver: random back-pressure, a long hold when asked, none in the steady stretch.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_words.size() == 0) begin
        report($sformatf("word with none due: status %0d tag %h", status_o, out_tag_o));
      end else begin
        oldest = due_words.pop_front();
        if (status_o !== oldest.status || out_tag_o !== oldest.tag ||
            credit_after_o !== oldest.credit || last_o !== oldest.last) begin
          report($sformatf("got status %0d tag %h credit %0d last %b, due %0d %h %0d %b",
                           status_o, out_tag_o, credit_after_o, last_o,
                           oldest.status, oldest.tag, oldest.credit, oldest.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("credit_throttle_with_queue_tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int                  span;
    logic [AMOUNT_W-1:0] amt;
    ctq_kind_e           kind;
    word_t               want;

    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    req_type_i  = KIND_REQUEST;
    amount_i    = '0;
    tag_i       = '0;
    out_ready_i = 1'b0;

    // Unlimited after reset, then a limited bucket that goes negative and queues.
    add_row(ROW_WORD, KIND_REQUEST, '1, 8'hFF, 1, 1'b1, ST_GRANTED, '0);
    add_row(ROW_RATE, KIND_REQUEST, 32'd100, '0, 1, 1'b0, ST_GRANTED, '0);
    add_row(ROW_WORD, KIND_REQUEST, 32'd150, 8'h01, 1, 1'b1, ST_GRANTED, -34'sd50);
    add_row(ROW_WORD, KIND_REQUEST, 32'd10, 8'h02, 1, 1'b1, ST_QUEUED, -34'sd50);
    add_row(ROW_WORD, KIND_REQUEST, 32'd0, 8'h03, 1, 1'b1, ST_GRANTED, -34'sd50);
    add_row(ROW_WORD, KIND_REQUEST, 32'd20, 8'h04, 1, 1'b0, ST_GRANTED, '0);
    add_row(ROW_WORD, KIND_TICK, 32'hAAAA_AAAA, 8'h55, 1, 1'b0, ST_GRANTED, '0);
    // Drive the credit far below zero, fill the queue, and overflow it.
    add_row(ROW_WORD, KIND_REQUEST, '1, 8'h80, 1, 1'b0, ST_GRANTED, '0);
    add_row(ROW_WORD, KIND_REQUEST, 32'd1, 8'h10, QUEUE_DEPTH, 1'b0, ST_GRANTED, '0);
    add_row(ROW_WORD, KIND_REQUEST, 32'd5, 8'hC0, 1, 1'b1, ST_REJECTED, -34'sd4294967275);
    // Unlimited tick empties the leftover queue free of charge, up to the cap.
    add_row(ROW_RATE, KIND_REQUEST, 32'd0, '0, 1, 1'b0, ST_GRANTED, '0);
    add_row(ROW_WORD, KIND_TICK, 32'd0, '0, 1, 1'b0, ST_GRANTED, '0);
    // Largest rate: the second tick saturates the credit.
    add_row(ROW_RATE, KIND_REQUEST, '1, '0, 1, 1'b0, ST_GRANTED, '0);
    add_row(ROW_WORD, KIND_TICK, '0, '0, 1, 1'b1, ST_NONE, 34'sh1_FFFF_FFFE);
    add_row(ROW_WORD, KIND_TICK, '1, '0, 1, 1'b1, ST_NONE, 34'sh1_FFFF_FFFF);
    // Lowest credit reachable: one unit left, then the largest request.
    add_row(ROW_RATE, KIND_REQUEST, 32'd1, '0, 1, 1'b0, ST_GRANTED, '0);
    add_row(ROW_WORD, KIND_REQUEST, '1, 8'h7F, 1, 1'b1, ST_GRANTED, -34'sd4294967294);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      case (plan[i].op)
        ROW_RATE: begin
          settle();
          write_rate(plan[i].amount);
        end
        ROW_WORD: begin
          for (int k = 0; k < plan[i].reps; k++) begin
            want = '{status: plan[i].status, tag: plan[i].tag + k[TAG_W-1:0],
                     credit: plan[i].credit, last: 1'b1};
            send_word(plan[i].kind, plan[i].amount, plan[i].tag + k[TAG_W-1:0],
                      plan[i].typed, want);
          end
        end
      endcase
    end

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: write_rate(32'd100);
        1: write_rate(32'd0);
        2: write_rate(32'd1);
        3: write_rate('1);
        4: write_rate($urandom_range(20, 400));
        5: write_rate($urandom());
        6: write_rate(32'd250);
        default: write_rate(32'd64);
      endcase
      steady = (ph == 6);
      // The first phase starts with the receiver held off, so the block backs up.
      if (ph == 0) begin
        hold_left = HOLD_CYCLES;
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (ph == 4 && i == PHASE_WORDS / 2) begin
          settle();
        end
        span = (model_rate == '0 || model_rate > 32'd600) ? 600 : 2 * int'(model_rate);
        kind = ($urandom_range(99) < 15) ? KIND_TICK : KIND_REQUEST;
        case ($urandom_range(9))
          0: amt = '0;
          1: amt = '1;
          2: amt = $urandom();
          default: amt = $urandom_range(1, span);
        endcase
        send_word(kind, amt, TAG_W'($urandom_range(255)), 1'b0, '0);
      end
    end
    steady = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (2 * MAX_RESULTS) @(posedge clk_i);
    if (errors == 0) begin
      $display("credit_throttle_with_queue_tb: done, clean");
    end else begin
      $display("credit_throttle_with_queue_tb: done, errors");
    end
    $finish;
  end

endmodule
